// File: hw/rtl/wcfe_pkg.sv
`default_nettype none

package wcfe_pkg;

  // frame layout
  localparam int FRAME_LEN = 21;
  localparam int SUM_LEN   = 17;
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);

  // frame byte codes
  localparam logic [7:0] BYTE_START   = 8'h01;
  localparam logic [7:0] BYTE_BASE    = 8'h30;
  localparam logic [7:0] BYTE_PRESS   = 8'h3A;
  localparam logic [7:0] BYTE_CR      = 8'h0d;
  localparam logic [7:0] BYTE_LF      = 8'h0a;
  localparam logic [7:0] NIB_HI_MASK  = 8'hf0;
  localparam logic [7:0] NIB_LO_MASK  = 8'h0f;

  // robot layouts
  localparam logic KIND_FOUR_WHEEL  = 1'b0;
  localparam logic KIND_THREE_WHEEL = 1'b1;

  typedef logic signed [8:0] speed_t;
  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  // serializer status toward the input side
  typedef struct packed {
    logic load;
    logic ready;
  } ser_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/wcfe_encode.sv
`default_nettype none

module wcfe_encode (
  input  wire logic             robot_kind,
  input  wire wcfe_pkg::speed_t speed_wheel_a,
  input  wire wcfe_pkg::speed_t speed_wheel_b,
  input  wire wcfe_pkg::speed_t speed_wheel_c,
  input  wire wcfe_pkg::speed_t speed_wheel_d,
  output wcfe_pkg::frame_t      frame
);

  // three bytes of one wheel slot, first byte at index 0
  function automatic logic [2:0][7:0] wheel_bytes(input wcfe_pkg::speed_t s);
    logic            en;
    logic            dir;
    logic [8:0]      neg;
    logic [7:0]      mag;
    logic [2:0][7:0] b;
    en   = (s != '0);
    dir  = s[8];
    neg  = 9'(~s + 9'sd1);
    mag  = dir ? neg[7:0] : s[7:0];
    b[0] = wcfe_pkg::BYTE_BASE | {6'b0, dir, en};
    b[1] = wcfe_pkg::BYTE_BASE | ((mag & wcfe_pkg::NIB_HI_MASK) >> 4);
    b[2] = wcfe_pkg::BYTE_BASE | (mag & wcfe_pkg::NIB_LO_MASK);
    return b;
  endfunction

  logic [2:0][7:0] slot1, slot2, slot3, slot4;
  logic [7:0]      sum;

  // slot order follows the robot layout
  always_comb begin
    if (robot_kind == wcfe_pkg::KIND_THREE_WHEEL) begin
      slot1 = {wcfe_pkg::BYTE_BASE, wcfe_pkg::BYTE_BASE, wcfe_pkg::BYTE_BASE};
      slot2 = wheel_bytes(speed_wheel_a);
      slot3 = wheel_bytes(speed_wheel_c);
      slot4 = wheel_bytes(speed_wheel_b);
    end else begin
      slot1 = wheel_bytes(speed_wheel_a);
      slot2 = wheel_bytes(speed_wheel_b);
      slot3 = wheel_bytes(speed_wheel_d);
      slot4 = wheel_bytes(speed_wheel_c);
    end
  end

  // frame assembly and checksum
  always_comb begin
    frame = '0;
    frame[0] = wcfe_pkg::BYTE_START;
    for (int i = 0; i < 3; i++) begin
      frame[1 + i]  = slot1[i];
      frame[4 + i]  = slot2[i];
      frame[7 + i]  = slot3[i];
      frame[10 + i] = slot4[i];
    end
    frame[13] = wcfe_pkg::BYTE_BASE;
    frame[14] = (robot_kind == wcfe_pkg::KIND_THREE_WHEEL) ?
                wcfe_pkg::BYTE_PRESS : wcfe_pkg::BYTE_BASE;
    frame[15] = wcfe_pkg::BYTE_BASE;
    frame[16] = wcfe_pkg::BYTE_BASE;
    sum = '0;
    for (int i = 0; i < wcfe_pkg::SUM_LEN; i++) begin
      sum = sum ^ frame[i];
    end
    frame[17] = wcfe_pkg::BYTE_BASE | ((sum & wcfe_pkg::NIB_HI_MASK) >> 4);
    frame[18] = wcfe_pkg::BYTE_BASE | (sum & wcfe_pkg::NIB_LO_MASK);
    frame[19] = wcfe_pkg::BYTE_CR;
    frame[20] = wcfe_pkg::BYTE_LF;
  end

endmodule

`default_nettype wire

// File: hw/rtl/wcfe_serializer.sv
`default_nettype none

module wcfe_serializer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              frame_valid,
  input  wire wcfe_pkg::frame_t  frame,
  output wcfe_pkg::ser_ctl_t     ctl,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_frame_byte,
  output logic                   out_frame_last
);

  wcfe_pkg::frame_t                frame_r, frame_nxt;
  logic [wcfe_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            take;

  // a beat leaves when valid and not stalled
  assign take = (cnt_r != '0) && !out_stall;

  // free for a new frame when empty or when the last beat leaves now
  assign ctl.ready = (cnt_r == '0) ||
                     ((cnt_r == wcfe_pkg::CNT_W'(1)) && take);
  assign ctl.load  = ctl.ready && frame_valid;

  // shift out one byte per accepted beat, reload back to back
  always_comb begin
    frame_nxt = frame_r;
    cnt_nxt   = cnt_r;
    if (ctl.load) begin
      frame_nxt = frame;
      cnt_nxt   = wcfe_pkg::CNT_W'(wcfe_pkg::FRAME_LEN);
    end else if (take) begin
      frame_nxt = frame_r >> 8;
      cnt_nxt   = cnt_r - wcfe_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid      = (cnt_r != '0);
  assign out_frame_byte = frame_r[0];
  assign out_frame_last = (cnt_r == wcfe_pkg::CNT_W'(1));

endmodule

`default_nettype wire

// File: hw/rtl/wheel_command_frame_encoder.sv
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------
// in_      | input     | in_valid / in_stall  | in_speed_wheel_a..d, 9 bit signed
// out_     | output    | out_valid/out_stall  | out_frame_byte 8 bit, out_frame_last
// cfg_     | input     | cfg_we               | cfg_robot_kind, 1 bit
//
// 21 output beats per speed set, one per cycle while out_stall is low, so the byte
// serializer sets the rate; the held beat loads as the last byte of the
// previous frame leaves, so frames follow with no gap
// from idle, an accepted set passes the hold register, then the serializer, to out_
// reset clears all valids and sets robot_kind to four-wheel layout
// out_stall freezes the byte shown; in_stall rises once a beat waits held

module wheel_command_frame_encoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_robot_kind,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wcfe_pkg::speed_t    in_speed_wheel_a,
  input  wire wcfe_pkg::speed_t    in_speed_wheel_b,
  input  wire wcfe_pkg::speed_t    in_speed_wheel_c,
  input  wire wcfe_pkg::speed_t    in_speed_wheel_d,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_frame_byte,
  output logic                     out_frame_last
);

  logic               robot_kind_r;
  logic               hold_valid_r, hold_valid_nxt;
  wcfe_pkg::speed_t   spd_a_r, spd_b_r, spd_c_r, spd_d_r;
  wcfe_pkg::frame_t   frame;
  wcfe_pkg::ser_ctl_t ser_ctl;
  logic               in_take;

  // input register accepts when empty or being drained this cycle
  assign in_stall = hold_valid_r && !ser_ctl.load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_take) begin
      hold_valid_nxt = 1'b1;
    end else if (ser_ctl.load) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      spd_a_r <= in_speed_wheel_a;
      spd_b_r <= in_speed_wheel_b;
      spd_c_r <= in_speed_wheel_c;
      spd_d_r <= in_speed_wheel_d;
    end
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      robot_kind_r <= wcfe_pkg::KIND_FOUR_WHEEL;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (cfg_we) begin
        robot_kind_r <= cfg_robot_kind;
      end
    end
  end

  // frame encode
  wcfe_encode u_encode (
    .robot_kind    (robot_kind_r),
    .speed_wheel_a (spd_a_r),
    .speed_wheel_b (spd_b_r),
    .speed_wheel_c (spd_c_r),
    .speed_wheel_d (spd_d_r),
    .frame         (frame)
  );

  // byte serializer
  wcfe_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_valid    (hold_valid_r),
    .frame          (frame),
    .ctl            (ser_ctl),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire
